// File: design/jacobi_five_point_sweep_top_defines.svh
// ----------------------------------------------------------------------------
// Jacobi five-point sweep assertion macros
// Concurrent check wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef JACOBI_FIVE_POINT_SWEEP_TOP_DEFINES_SVH
`define JACOBI_FIVE_POINT_SWEEP_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while rst_n is low
`define JFS_ASSERT_IMPLIES(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("jfs check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define JFS_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("jfs check failed");

`else

`define JFS_ASSERT_IMPLIES(name, cond, prop)
`define JFS_ASSERT_NEXT(name, cond, prop)

`endif

`endif

// File: design/jfs_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi five-point sweep package
// Field widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package jfs_pkg;

    localparam int DEFAULT_MAX_WIDTH = 256;
    localparam int DEFAULT_MAX_ROWS  = 4096;

    localparam int VALUE_W     = 32;
    localparam int COL_W       = 9;
    localparam int ROW_W       = 13;
    localparam int STEP_W      = 32;
    localparam int SUM_W       = 63;
    localparam int SQ_W        = 41;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SQ    = 2'd2;

    localparam logic [COL_W-1:0]  RESET_GRID_WIDTH = 9'd256;
    localparam logic [ROW_W-1:0]  RESET_ROW_COUNT  = 13'd4096;
    localparam logic [STEP_W-1:0] RESET_STEP_SQ    = 32'd65026;

    localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

    localparam logic [VALUE_W-1:0] VALUE_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic             emit;
        logic             start;
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } point_meta_t;

endpackage

`default_nettype wire

// File: design/jfs_grid_if.sv
// ----------------------------------------------------------------------------
// Grid point channel
// One padded grid point per transfer, raster order.
// ----------------------------------------------------------------------------
`default_nettype none

interface jfs_grid_if
    import jfs_pkg::*;
();

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] u_value;
    logic signed [VALUE_W-1:0] forcing;
    logic                      grid_start;

    modport source (output valid, output u_value, output forcing, output grid_start,
                    input ready);
    modport sink   (input valid, input u_value, input forcing, input grid_start,
                    output ready);

endinterface

`default_nettype wire

// File: design/jfs_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// One updated interior point per transfer with its running change sum.
// ----------------------------------------------------------------------------
`default_nettype none

interface jfs_result_if
    import jfs_pkg::*;
();

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] new_value;
    logic [COL_W-1:0]          col_index;
    logic [ROW_W-1:0]          row_index;
    logic [SUM_W-1:0]          change_sum;
    logic                      last;

    modport source (output valid, output new_value, output col_index, output row_index,
                    output change_sum, output last, input ready);
    modport sink   (input valid, input new_value, input col_index, input row_index,
                    input change_sum, input last, output ready);

endinterface

`default_nettype wire

// File: design/jfs_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data, one register per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface jfs_cfg_if
    import jfs_pkg::*;
();

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

`default_nettype wire

// File: design/jacobi_five_point_sweep_top.sv
// ----------------------------------------------------------------------------
// Jacobi five-point sweep
// Streams a padded grid, keeps two solution rows and one forcing row in RAM,
// and emits the stencil update and running squared change per interior point.
// ----------------------------------------------------------------------------
//  channel  | role | payload
//  ---------+------+------------------------------------------------
//  cfg      | sink | index, data (grid_width, row_count, step_sq)
//  grid     | sink | u_value, forcing, grid_start
//  result   | src  | new_value, col_index, row_index, change_sum, last
//
//  A grid point is taken only while the read stage is empty: the line RAMs
//  are read in the transfer cycle and written back as the point leaves it.
//  Results are registered through the pipeline stages and an output register.
//  Reset clears counters, sum and valid flags; RAM contents stay undefined.
//  A stalled result holds the whole pipeline; one more point may enter the
//  read stage, after which grid.ready stays low until the stall clears.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jacobi_five_point_sweep_top_defines.svh"

module jacobi_five_point_sweep_top
    import jfs_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
    parameter int MAX_ROWS  = DEFAULT_MAX_ROWS
) (
    input  logic         clk,
    input  logic         rst_n,
    jfs_cfg_if.sink      cfg,
    jfs_grid_if.sink     grid,
    jfs_result_if.source result
);

    localparam int DEPTH     = MAX_WIDTH + 2;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 3);
    localparam int W_CMP_W   = ((COL_W > ADDR_W) ? COL_W : ADDR_W) + 1;
    localparam int R_CMP_W   = ((ROW_W > ROW_CNT_W) ? ROW_W : ROW_CNT_W) + 1;

    localparam logic signed [33:0] NV_MAX = 34'sd2147483647;
    localparam logic signed [33:0] NV_MIN = -34'sd2147483648;

    // configuration
    logic [COL_W-1:0]  grid_width_reg;
    logic [ROW_W-1:0]  row_count_reg;
    logic [STEP_W-1:0] step_sq_reg;

    // position
    logic [ADDR_W-1:0]    col_reg, col_next;
    logic [ROW_CNT_W-1:0] row_reg, row_next;

    logic [W_CMP_W-1:0]   w_eff, w_plus2, col_inc;
    logic [R_CMP_W-1:0]   rows_eff, rows_plus2;
    logic [ADDR_W-1:0]    col_base, col_cur, col_after;
    logic [ROW_CNT_W-1:0] row_base, row_cur, row_out;
    logic                 col_wrap, drop_item, emit_item, end_row, accept, accept_item;
    logic                 advance;

    // stage 1: RAM read
    logic                      s1_valid_reg;
    point_meta_t               s1_meta_reg, s1_meta_next;
    logic [ADDR_W-1:0]         s1_col_reg;
    logic signed [VALUE_W-1:0] s1_u_reg, s1_f_reg;
    logic signed [VALUE_W-1:0] north_q, center_q, east_q, fc_q;
    logic signed [VALUE_W-1:0] west_reg;
    logic [ADDR_W-1:0]         east_addr;
    logic                      store_we;

    // stage 2: neighbor sum and forcing product
    logic                      s2_valid_reg;
    point_meta_t               s2_meta_reg;
    logic signed [33:0]        s2_sum_reg, s2_sum_next;
    logic signed [63:0]        s2_prod_reg, s2_prod_next;
    logic signed [VALUE_W-1:0] s2_center_reg;
    logic signed [32:0]        step_s;
    logic signed [64:0]        prod_full;

    // stage 3: numerator
    logic                      s3_valid_reg;
    point_meta_t               s3_meta_reg;
    logic signed [34:0]        s3_a_reg, s3_a_next;
    logic [31:0]               s3_pl_reg;
    logic signed [VALUE_W-1:0] s3_center_reg;

    // stage 4: divide by four, round, saturate
    logic                      s4_valid_reg;
    point_meta_t               s4_meta_reg;
    logic signed [VALUE_W-1:0] s4_nv_reg, s4_nv_next;
    logic signed [VALUE_W-1:0] s4_center_reg;
    logic signed [32:0]        q4;
    logic                      rnd;
    logic signed [33:0]        n_full;

    // stage 5: magnitude of change
    logic                      s5_valid_reg;
    point_meta_t               s5_meta_reg;
    logic signed [VALUE_W-1:0] s5_nv_reg;
    logic [32:0]               s5_ad_reg, s5_ad_next;
    logic [32:0]               diff;

    // stage 6: squared change
    logic                      s6_valid_reg;
    point_meta_t               s6_meta_reg;
    logic signed [VALUE_W-1:0] s6_nv_reg;
    logic [SQ_W-1:0]           s6_sq_reg;
    logic [65:0]               sq_full;

    // output stage and sum
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_nv_reg;
    logic [COL_W-1:0]          out_col_reg;
    logic [ROW_W-1:0]          out_row_reg;
    logic [SUM_W-1:0]          out_sum_reg;
    logic                      out_last_reg;
    logic [SUM_W-1:0]          acc_reg, acc_next, acc_base, acc_sat;
    logic [SUM_W:0]            acc_sum;

    // ------------------------------------------------------------------ config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= RESET_GRID_WIDTH;
            row_count_reg  <= RESET_ROW_COUNT;
            step_sq_reg    <= RESET_STEP_SQ;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GRID_WIDTH: grid_width_reg <= cfg.data[COL_W-1:0];
                REG_ROW_COUNT:  row_count_reg  <= cfg.data[ROW_W-1:0];
                REG_STEP_SQ:    step_sq_reg    <= cfg.data[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------- position
    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = W_CMP_W'(1);
        else if (W_CMP_W'(grid_width_reg) > W_CMP_W'(MAX_WIDTH))
            w_eff = W_CMP_W'(MAX_WIDTH);
        else
            w_eff = W_CMP_W'(grid_width_reg);

        if (row_count_reg == '0)
            rows_eff = R_CMP_W'(1);
        else if (R_CMP_W'(row_count_reg) > R_CMP_W'(MAX_ROWS))
            rows_eff = R_CMP_W'(MAX_ROWS);
        else
            rows_eff = R_CMP_W'(row_count_reg);

        w_plus2    = w_eff + W_CMP_W'(2);
        rows_plus2 = rows_eff + R_CMP_W'(2);

        col_base = grid.grid_start ? '0 : col_reg;
        row_base = grid.grid_start ? '0 : row_reg;
        col_wrap = W_CMP_W'(col_base) >= w_plus2;
        col_cur  = col_wrap ? '0 : col_base;
        row_cur  = (col_wrap && (R_CMP_W'(row_base) < rows_plus2))
                   ? row_base + ROW_CNT_W'(1) : row_base;

        drop_item = R_CMP_W'(row_cur) >= rows_plus2;
        emit_item = (row_cur >= ROW_CNT_W'(2)) && (col_cur != '0)
                    && (W_CMP_W'(col_cur) <= w_eff);
        row_out   = row_cur - ROW_CNT_W'(1);

        col_inc   = W_CMP_W'(col_cur) + W_CMP_W'(1);
        end_row   = col_inc >= w_plus2;
        col_after = end_row ? '0 : ADDR_W'(col_inc);
        east_addr = ADDR_W'(col_inc);

        if (drop_item)
        begin
            col_next = col_cur;
            row_next = row_cur;
        end
        else
        begin
            col_next = col_after;
            row_next = end_row ? row_cur + ROW_CNT_W'(1) : row_cur;
        end

        s1_meta_next.emit  = emit_item;
        s1_meta_next.start = grid.grid_start;
        s1_meta_next.last  = (R_CMP_W'(row_out) == rows_eff) && (W_CMP_W'(col_cur) == w_eff);
        s1_meta_next.col   = COL_W'(col_cur);
        s1_meta_next.row   = ROW_W'(row_out);
    end

    assign advance     = !out_valid_reg || result.ready;
    assign grid.ready  = !s1_valid_reg;
    assign accept      = grid.valid && grid.ready;
    assign accept_item = accept && !drop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------- line RAMs
    assign store_we = s1_valid_reg && advance;

    jfs_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_above_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (s1_col_reg),
        .wdata (center_q),
        .re    (accept_item),
        .raddr (col_cur),
        .rdata (north_q)
    );

    jfs_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_center_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (s1_col_reg),
        .wdata (s1_u_reg),
        .re    (accept_item),
        .raddr (col_cur),
        .rdata (center_q)
    );

    jfs_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_east_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (s1_col_reg),
        .wdata (s1_u_reg),
        .re    (accept_item),
        .raddr (east_addr),
        .rdata (east_q)
    );

    jfs_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_forcing_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (s1_col_reg),
        .wdata (s1_f_reg),
        .re    (accept_item),
        .raddr (col_cur),
        .rdata (fc_q)
    );

    // -------------------------------------------------------------- datapath
    assign step_s    = {1'b0, step_sq_reg};
    assign prod_full = fc_q * step_s;

    always_comb
    begin
        s2_sum_next  = 34'(west_reg) + 34'(east_q) + 34'(north_q) + 34'(s1_u_reg);
        s2_prod_next = prod_full[63:0];

        s3_a_next = 35'(s2_sum_reg) - 35'($signed(s2_prod_reg[63:32]));

        // round half up on the dropped two bits plus product fraction
        q4  = s3_a_reg[34:2];
        rnd = (s3_a_reg[1:0] == 2'd3) || ((s3_a_reg[1:0] == 2'd2) && (s3_pl_reg == '0));
        n_full = 34'(q4) + {33'b0, rnd};
        if (n_full > NV_MAX)
            s4_nv_next = VALUE_POS_MAX;
        else if (n_full < NV_MIN)
            s4_nv_next = VALUE_NEG_MAX;
        else
            s4_nv_next = n_full[VALUE_W-1:0];

        diff       = 33'(s4_nv_reg) - 33'(s4_center_reg);
        s5_ad_next = diff[32] ? (~diff + 33'd1) : diff;
    end

    assign sq_full = s5_ad_reg * s5_ad_reg;

    always_comb
    begin
        acc_base = s6_meta_reg.start ? '0 : acc_reg;
        acc_sum  = {1'b0, acc_base} + (SUM_W + 1)'(s6_sq_reg);
        acc_sat  = acc_sum[SUM_W] ? SUM_LIMIT : acc_sum[SUM_W-1:0];
        acc_next = acc_reg;
        if (s6_valid_reg && advance)
            acc_next = s6_meta_reg.emit ? acc_sat : acc_base;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = s6_valid_reg && s6_meta_reg.emit;
    end

    // ------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            west_reg      <= '0;
        end
        else
        begin
            if (accept_item)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
            begin
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
                s6_valid_reg <= s5_valid_reg;
            end
            if (store_we)
                west_reg <= center_q;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    // ------------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        if (accept_item)
        begin
            s1_meta_reg <= s1_meta_next;
            s1_col_reg  <= col_cur;
            s1_u_reg    <= grid.u_value;
            s1_f_reg    <= grid.forcing;
        end
        if (advance)
        begin
            s2_meta_reg   <= s1_meta_reg;
            s2_sum_reg    <= s2_sum_next;
            s2_prod_reg   <= s2_prod_next;
            s2_center_reg <= center_q;

            s3_meta_reg   <= s2_meta_reg;
            s3_a_reg      <= s3_a_next;
            s3_pl_reg     <= s2_prod_reg[31:0];
            s3_center_reg <= s2_center_reg;

            s4_meta_reg   <= s3_meta_reg;
            s4_nv_reg     <= s4_nv_next;
            s4_center_reg <= s3_center_reg;

            s5_meta_reg <= s4_meta_reg;
            s5_nv_reg   <= s4_nv_reg;
            s5_ad_reg   <= s5_ad_next;

            s6_meta_reg <= s5_meta_reg;
            s6_nv_reg   <= s5_nv_reg;
            s6_sq_reg   <= sq_full[64:24];

            if (s6_valid_reg && s6_meta_reg.emit)
            begin
                out_nv_reg   <= s6_nv_reg;
                out_col_reg  <= s6_meta_reg.col;
                out_row_reg  <= s6_meta_reg.row;
                out_sum_reg  <= acc_sat;
                out_last_reg <= s6_meta_reg.last;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.new_value  = out_nv_reg;
    assign result.col_index  = out_col_reg;
    assign result.row_index  = out_row_reg;
    assign result.change_sum = out_sum_reg;
    assign result.last       = out_last_reg;

    // -------------------------------------------------------------- checks
    `JFS_ASSERT_IMPLIES(a_col_in_range, 1'b1, col_reg <= ADDR_W'(MAX_WIDTH + 1))
    `JFS_ASSERT_NEXT(a_read_before_write, accept_item, !grid.ready)
    `JFS_ASSERT_NEXT(a_sum_monotonic, s6_valid_reg && advance && !s6_meta_reg.start, acc_reg >= $past(acc_reg))
    `JFS_ASSERT_IMPLIES(a_last_interior, result.valid && result.last, (result.col_index != '0) && (result.row_index != '0))

endmodule

`default_nettype wire

// File: design/jfs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module jfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 258
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/jacobi_five_point_sweep_top_tb.sv
// ----------------------------------------------------------------------------
// Jacobi five-point sweep testbench
// Streams padded grids through the sweep block and checks every interior
// update, its position, the running squared change and the last flag against
// a predictor that follows the same fixed-point arithmetic.
// Small grids with random content dominate. One grid runs above the widest
// setting and breaks off after its first interior points, and some phases
// break off, restart, add noise or shrink the width in the middle of a row.
// ----------------------------------------------------------------------------
module jacobi_five_point_sweep_top_tb
    import jfs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH    = DEFAULT_MAX_WIDTH + 2;
    localparam int BUSY_PCT       = 16;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 850;
    localparam int PRINT_LIMIT    = 30;

    typedef enum {FILL_RANDOM, FILL_HIGH, FILL_LOW} fill_t;

    typedef struct {
        logic signed [VALUE_W-1:0] u_value;
        logic signed [VALUE_W-1:0] forcing;
        logic                      grid_start;
    } grid_point_t;

    typedef struct {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } reg_write_t;

    typedef struct {
        logic signed [VALUE_W-1:0] new_value;
        logic [COL_W-1:0]          col_index;
        logic [ROW_W-1:0]          row_index;
        logic [SUM_W-1:0]          change_sum;
        logic                      last;
    } sweep_result_t;

    logic clk = 1'b0;
    logic rst_n;

    jfs_cfg_if    cfg_ch ();
    jfs_grid_if   grid_ch ();
    jfs_result_if res_ch ();

    jacobi_five_point_sweep_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .grid   (grid_ch),
        .result (res_ch)
    );

    always #4 clk = ~clk;

    grid_point_t   pending_points[$];
    reg_write_t    pending_writes[$];
    sweep_result_t expected_updates[$];

    int unsigned points_queued = 0;
    int unsigned points_taken  = 0;
    int unsigned writes_queued = 0;
    int unsigned writes_done   = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles  = 0;
    int          idle_pct      = BUSY_PCT;

    // predictor state
    logic [COL_W-1:0]          width_reg = RESET_GRID_WIDTH;
    logic [ROW_W-1:0]          rows_reg  = RESET_ROW_COUNT;
    logic [STEP_W-1:0]         step_reg  = RESET_STEP_SQ;
    logic signed [VALUE_W-1:0] north_row   [0:STORE_DEPTH-1];
    logic signed [VALUE_W-1:0] center_row  [0:STORE_DEPTH-1];
    logic signed [VALUE_W-1:0] forcing_row [0:STORE_DEPTH-1];
    logic signed [VALUE_W-1:0] west_reg = '0;
    logic [SUM_W-1:0]          change_acc = '0;
    int unsigned               col_pos = 0;
    int unsigned               row_pos = 0;

    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > DEFAULT_MAX_WIDTH)
            return DEFAULT_MAX_WIDTH;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned eff_rows();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > DEFAULT_MAX_ROWS)
            return DEFAULT_MAX_ROWS;
        return 32'(rows_reg);
    endfunction

    function automatic void apply_write(logic [CFG_INDEX_W-1:0] index,
                                        logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_GRID_WIDTH: width_reg = data[COL_W-1:0];
            REG_ROW_COUNT:  rows_reg  = data[ROW_W-1:0];
            REG_STEP_SQ:    step_reg  = data;
            default: ;
        endcase
    endfunction

    // (neighbors - h^2 * f) / 4, rounded half up, saturated
    function automatic logic signed [VALUE_W-1:0] relaxed_value(
            logic signed [VALUE_W+1:0] neighbor_sum, logic signed [VALUE_W-1:0] f);
        logic signed [63:0] product;
        logic signed [63:0] product_hi;
        logic signed [63:0] a;
        logic signed [63:0] q;
        logic signed [63:0] n;
        logic [63:0]        frac;
        product    = f * $signed({32'd0, step_reg});
        product_hi = product >>> 32;
        a          = neighbor_sum - product_hi;
        q          = a >>> 2;
        frac       = {30'd0, a[1:0], 32'd0} + 64'h2_0000_0000 - {32'd0, product[31:0]};
        n          = q + $signed(frac >> 34);
        if (n > 64'sd2147483647)
            return VALUE_POS_MAX;
        if (n < -64'sd2147483648)
            return VALUE_NEG_MAX;
        return n[VALUE_W-1:0];
    endfunction

    function automatic void sweep_point(logic signed [VALUE_W-1:0] u,
                                        logic signed [VALUE_W-1:0] f, logic start);
        int unsigned               w;
        int unsigned               rows;
        int unsigned               c;
        logic signed [VALUE_W-1:0] north;
        logic signed [VALUE_W-1:0] center;
        logic signed [VALUE_W-1:0] east;
        logic signed [VALUE_W-1:0] fc;
        logic signed [VALUE_W-1:0] west;
        logic signed [VALUE_W+1:0] neighbor_sum;
        logic signed [VALUE_W:0]   delta;
        logic [63:0]               mag;
        logic [63:0]               sq;
        logic [63:0]               acc;
        logic [63:0]               limit;
        sweep_result_t             upd;
        bit                        emit;
        w    = eff_width();
        rows = eff_rows();
        if (start)
        begin
            col_pos    = 0;
            row_pos    = 0;
            change_acc = '0;
        end
        if (col_pos >= w + 2)
        begin
            col_pos = 0;
            if (row_pos < rows + 2)
                row_pos++;
        end
        if (row_pos >= rows + 2)
            return;
        c      = col_pos;
        north  = north_row[c];
        center = center_row[c];
        east   = (c + 1 < STORE_DEPTH) ? center_row[c+1] : '0;
        fc     = forcing_row[c];
        west   = west_reg;
        emit   = row_pos >= 2 && c >= 1 && c <= w;

        west_reg       = center;
        north_row[c]   = center;
        center_row[c]  = u;
        forcing_row[c] = f;

        if (emit)
        begin
            neighbor_sum  = west + east + north + u;
            upd.new_value = relaxed_value(neighbor_sum, fc);
            delta         = upd.new_value - center;
            mag           = (delta < 0) ? -delta : delta;
            sq            = (mag * mag) >> 24;
            acc           = {1'b0, change_acc};
            limit         = {1'b0, SUM_LIMIT};
            if (acc > limit - sq)
                change_acc = SUM_LIMIT;
            else
                change_acc = acc[SUM_W-1:0] + sq[SUM_W-1:0];
            upd.col_index  = c[COL_W-1:0];
            upd.row_index  = ROW_W'(row_pos - 1);
            upd.change_sum = change_acc;
            upd.last       = (row_pos - 1 == rows) && (c == w);
            expected_updates.push_back(upd);
        end

        col_pos++;
        if (col_pos >= w + 2)
        begin
            col_pos = 0;
            row_pos++;
        end
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // grid driver
    always @(posedge clk)
    begin : grid_driver
        grid_point_t next_point;
        if (rst_n)
        begin
            if (grid_ch.valid && grid_ch.ready)
            begin
                sweep_point(grid_ch.u_value, grid_ch.forcing, grid_ch.grid_start);
                points_taken++;
            end
            if (!grid_ch.valid || grid_ch.ready)
            begin
                if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    next_point         = pending_points.pop_front();
                    grid_ch.valid      <= 1'b1;
                    grid_ch.u_value    <= next_point.u_value;
                    grid_ch.forcing    <= next_point.forcing;
                    grid_ch.grid_start <= next_point.grid_start;
                end
                else
                    grid_ch.valid <= 1'b0;
            end
        end
    end

    // register write driver
    always @(posedge clk)
    begin : cfg_driver
        reg_write_t next_write;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                apply_write(cfg_ch.index, cfg_ch.data);
                writes_done++;
            end
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (pending_writes.size() != 0)
                begin
                    next_write   = pending_writes.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= next_write.index;
                    cfg_ch.data  <= next_write.data;
                end
                else
                    cfg_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        res_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        sweep_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_updates.size() == 0)
                report_mismatch("unexpected result col", 64'(res_ch.col_index), '0);
            else
            begin
                want = expected_updates.pop_front();
                if (res_ch.new_value !== want.new_value)
                    report_mismatch("new_value", 64'(res_ch.new_value),
                                    64'(want.new_value));
                if (res_ch.col_index !== want.col_index)
                    report_mismatch("col_index", 64'(res_ch.col_index),
                                    64'(want.col_index));
                if (res_ch.row_index !== want.row_index)
                    report_mismatch("row_index", 64'(res_ch.row_index),
                                    64'(want.row_index));
                if (res_ch.change_sum !== want.change_sum)
                    report_mismatch("change_sum", 64'(res_ch.change_sum),
                                    64'(want.change_sum));
                if (res_ch.last !== want.last)
                    report_mismatch("last", 64'(res_ch.last), 64'(want.last));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (grid_ch.valid && grid_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? VALUE_POS_MAX : VALUE_NEG_MAX;
            1, 2:    return r;
            default: return {{3{r[28]}}, r[28:0]};
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return RESET_STEP_SQ;
            3:       return $urandom();
            default: return $urandom_range(32'h0100_0000);
        endcase
    endfunction

    function automatic int unsigned pick_width();
        case ($urandom_range(19))
            0:       return 0;
            1, 2:    return $urandom_range(9, 40);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int unsigned pick_rows();
        return ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
    endfunction

    task automatic wait_idle();
        while (points_taken != points_queued || expected_updates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        reg_write_t wr;
        wr.index = index;
        wr.data  = data;
        pending_writes.push_back(wr);
        writes_queued++;
        while (writes_done != writes_queued)
            @(posedge clk);
    endtask

    // random upper bits ride along; the register keeps its own width
    task automatic set_width(int unsigned value);
        write_reg(REG_GRID_WIDTH, ($urandom() & ~32'h1FF) | value);
    endtask

    task automatic set_rows(int unsigned value);
        write_reg(REG_ROW_COUNT, ($urandom() & ~32'h1FFF) | value);
    endtask

    task automatic queue_point(logic signed [VALUE_W-1:0] u, logic signed [VALUE_W-1:0] f,
                               logic start);
        grid_point_t p;
        p.u_value    = u;
        p.forcing    = f;
        p.grid_start = start;
        pending_points.push_back(p);
        points_queued++;
    endtask

    task automatic queue_grid(bit with_start, int stop_after, fill_t fill);
        int total;
        total = (eff_width() + 2) * (eff_rows() + 2);
        if (stop_after >= 0 && stop_after < total)
            total = stop_after;
        for (int i = 0; i < total; i++)
        begin
            case (fill)
                FILL_HIGH: queue_point(VALUE_POS_MAX, VALUE_NEG_MAX, with_start && i == 0);
                FILL_LOW:  queue_point(VALUE_NEG_MAX, VALUE_POS_MAX, with_start && i == 0);
                default:   queue_point(pick_value(), pick_value(), with_start && i == 0);
            endcase
        end
    endtask

    task automatic queue_junk(int count);
        for (int i = 0; i < count; i++)
            queue_point(pick_value(), pick_value(), 1'b0);
    endtask

    task automatic run_big_grid(int unsigned w, int unsigned rows, int stop_after);
        set_width(w);
        set_rows(rows);
        write_reg(REG_STEP_SQ, pick_step());
        queue_grid(1'b1, stop_after, FILL_RANDOM);
        wait_idle();
    endtask

    initial
    begin
        int unsigned random_start;
        int unsigned phase;
        int unsigned kind;
        int unsigned wide;
        int unsigned keep;
        int          total;

        rst_n              = 1'b0;
        grid_ch.valid      = 1'b0;
        grid_ch.u_value    = '0;
        grid_ch.forcing    = '0;
        grid_ch.grid_start = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_GRID_WIDTH;
        cfg_ch.data        = '0;
        res_ch.ready       = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            north_row[i]   = '0;
            center_row[i]  = '0;
            forcing_row[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first grid without a start mark, reset step, positive saturation
        set_width(2);
        set_rows(2);
        queue_grid(1'b0, -1, FILL_HIGH);
        queue_junk(2);
        wait_idle();

        // negative saturation at the largest step
        set_width(1);
        set_rows(1);
        write_reg(REG_STEP_SQ, 32'hFFFF_FFFF);
        queue_grid(1'b1, -1, FILL_LOW);
        wait_idle();

        random_start = points_queued;
        phase        = 0;
        while (points_queued - random_start < RANDOM_ITEMS)
        begin
            idle_pct = (phase >= 4 && phase < 8) ? 0 : BUSY_PCT;
            kind     = $urandom_range(9);
            if (phase == 2)
                run_big_grid(511, 0, 2 * (DEFAULT_MAX_WIDTH + 2) + 24);
            else if (kind == 0)
            begin
                // shrink the width partway through a row
                wide = $urandom_range(4, 10);
                set_width(wide);
                set_rows($urandom_range(3, 6));
                if ($urandom_range(1))
                    write_reg(REG_STEP_SQ, pick_step());
                keep = 2 * (wide + 2) + $urandom_range(1, wide + 1);
                queue_grid(1'b1, keep, FILL_RANDOM);
                wait_idle();
                set_width($urandom_range(1, wide - 1));
                queue_grid(1'b0, -1, FILL_RANDOM);
            end
            else
            begin
                if ($urandom_range(1))
                    set_width(pick_width());
                if ($urandom_range(1))
                    set_rows(pick_rows());
                if ($urandom_range(2) == 0)
                    write_reg(REG_STEP_SQ, pick_step());
                if (kind == 1)
                begin
                    total = $urandom_range(10, 40);
                    for (int i = 0; i < total; i++)
                        queue_point(pick_value(), pick_value(),
                                    i == 0 || $urandom_range(19) == 0);
                end
                else if (kind == 2)
                begin
                    total = (eff_width() + 2) * (eff_rows() + 2);
                    queue_grid(1'b1, $urandom_range(1, total - 1), FILL_RANDOM);
                end
                else
                begin
                    queue_grid(1'b1, -1, FILL_RANDOM);
                    if (kind == 3)
                        queue_junk($urandom_range(1, 4));
                end
            end
            wait_idle();
            phase++;
        end

        idle_pct = BUSY_PCT;
        wait_idle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: jacobi_five_point_sweep_top.f
+incdir+design
design/jfs_pkg.sv
design/jfs_grid_if.sv
design/jfs_result_if.sv
design/jfs_cfg_if.sv
design/jfs_ram.sv
design/jacobi_five_point_sweep_top.sv
tb/sv/jacobi_five_point_sweep_top_tb.sv
